>>> rtl/wallclock_synced_square_wave_watchdog_defines.svh
// ----------------------------------------------------------------------------
// wallclock synced square wave watchdog: assertion macros
// Shared assertion forms for the watchdog block; clocked on clk.
// ----------------------------------------------------------------------------
`ifndef WALLCLOCK_SYNCED_SQUARE_WAVE_WATCHDOG_DEFINES_SVH
`define WALLCLOCK_SYNCED_SQUARE_WAVE_WATCHDOG_DEFINES_SVH

// checked only outside reset
`define WSSW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define WSSW_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/wssw_pkg.sv
// ----------------------------------------------------------------------------
// wssw_pkg
// Types, event and action codes and fixed constants of the square wave watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

package wssw_pkg;

	localparam int SEC_W    = 32;
	localparam int NSEC_W   = 30;
	localparam int PERIOD_W = 24;
	localparam int TOLP_W   = 7;
	localparam int HALF_W   = 23;
	localparam int Q100_W   = 17;
	localparam int TOL_W    = 24;
	localparam int DELAY_W  = 26;

	// event kinds
	localparam logic [1:0] FN_TOGGLE   = 2'd0;
	localparam logic [1:0] FN_WATCHDOG = 2'd1;
	localparam logic [1:0] FN_ENABLE   = 2'd2;
	localparam logic [1:0] FN_DISABLE  = 2'd3;

	// toggle timer actions
	localparam logic [1:0] TA_NONE  = 2'd0;
	localparam logic [1:0] TA_STOP  = 2'd1;
	localparam logic [1:0] TA_START = 2'd2;
	localparam logic [1:0] TA_FWD   = 2'd3;

	// watchdog actions
	localparam logic [1:0] WD_NONE   = 2'd0;
	localparam logic [1:0] WD_CANCEL = 2'd1;
	localparam logic [1:0] WD_ARM    = 2'd2;

	// register indexes
	localparam logic REG_PERIOD = 1'b0;
	localparam logic REG_TOL    = 1'b1;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd1000000;
	localparam logic [TOLP_W-1:0]   TOLP_RST   = 7'd100;
	localparam logic [Q100_W-1:0]   Q100_RST   = 17'd5000;
	localparam logic [TOL_W-1:0]    TOL_RST    = 24'd500000;

	// x / 100 for x below 2^23 as (x * DIV100_MUL) >> DIV100_SHIFT
	localparam logic [23:0] DIV100_MUL   = 24'd10737419;
	localparam int          DIV100_SHIFT = 30;

	localparam logic [DELAY_W-1:0] DELAY_MAX = 26'h3FFFFFF;
	localparam logic [31:0]        NS_PER_SEC = 32'd1000000000;

	typedef struct packed {
		logic [HALF_W-1:0] half;
		logic [TOL_W-1:0]  tol;
	} cfg_t;

	typedef struct packed {
		logic               out_level;
		logic [31:0]        restarts;
		logic               violation;
		logic [1:0]         timer_action;
		logic [SEC_W-1:0]   start_sec;
		logic [NSEC_W-1:0]  start_nsec;
		logic [HALF_W-1:0]  step_ns;
		logic [1:0]         watchdog_action;
		logic [DELAY_W-1:0] watchdog_delay_ns;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/wallclock_synced_square_wave_watchdog.sv
// ----------------------------------------------------------------------------
// wallclock synced square wave watchdog
// Takes wall-clock stamped events (toggle expiry, watchdog expiry, enable,
// disable) and returns one result per event: output level, restart count,
// violation flag and the actions for the toggle timer and the watchdog.
// Events are taken one per clock cycle while in_stall is low; each event passes
// an input register and a result register, so out_valid rises once the result
// register has been loaded from the input register. A result held by out_stall
// blocks a new transfer only once the input register is full.
// A write to the period or tolerance percent register is fully applied once
// the derived tolerance register has been updated from the new values.
// ----------------------------------------------------------------------------
`default_nettype none
`include "wallclock_synced_square_wave_watchdog_defines.svh"

module wallclock_synced_square_wave_watchdog import wssw_pkg::*; #(
	parameter int SLOT_NS = 10000000
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	// events
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         func,
	input  wire logic [SEC_W-1:0]   now_sec,
	input  wire logic [NSEC_W-1:0]  now_nsec,
	// results
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    out_level,
	output logic [31:0]             restarts,
	output logic                    violation,
	output logic [1:0]              timer_action,
	output logic [SEC_W-1:0]        start_sec,
	output logic [NSEC_W-1:0]       start_nsec,
	output logic [HALF_W-1:0]       step_ns,
	output logic [1:0]              watchdog_action,
	output logic [DELAY_W-1:0]      watchdog_delay_ns
);

	// now_nsec / SLOT_NS as a reciprocal multiply, exact over the 30-bit range
	localparam int          DIV_K = NSEC_W + $clog2(SLOT_NS);
	localparam int          MW    = DIV_K - $clog2(SLOT_NS) + 1;
	localparam int          PW    = NSEC_W + MW;
	localparam logic [63:0] DIV_M = ((64'd1 << DIV_K) + 64'(SLOT_NS) - 64'd1) / 64'(SLOT_NS);
	localparam int          QW    = $clog2(((1 << NSEC_W) - 1) / SLOT_NS + 1);

	cfg_t              cfg;
	res_t              ev_res;
	res_t              res_s2;
	logic              out_valid_s2;
	logic              valid_s1;
	logic [1:0]        func_s1;
	logic [SEC_W-1:0]  sec_s1;
	logic [NSEC_W-1:0] nsec_s1;
	logic [QW-1:0]     slotq_s1;
	logic [PW-1:0]     div_prod;
	logic              adv;
	logic              accept;
	logic              go;

	wssw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign div_prod = {MW'(0), now_nsec} * {NSEC_W'(0), DIV_M[MW-1:0]};

	// result register moves when empty or taken
	assign adv      = !out_valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;
	assign go       = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= func;
			sec_s1   <= now_sec;
			nsec_s1  <= now_nsec;
			slotq_s1 <= div_prod[DIV_K +: QW];
		end
		if (go) begin
			res_s2 <= ev_res;
		end
	end

	wssw_event #(
		.SLOT_NS (SLOT_NS),
		.QW      (QW)
	) u_event (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.func   (func_s1),
		.sec    (sec_s1),
		.nsec   (nsec_s1),
		.slotq  (slotq_s1),
		.cfg    (cfg),
		.res    (ev_res)
	);

	assign out_valid         = out_valid_s2;
	assign out_level         = res_s2.out_level;
	assign restarts          = res_s2.restarts;
	assign violation         = res_s2.violation;
	assign timer_action      = res_s2.timer_action;
	assign start_sec         = res_s2.start_sec;
	assign start_nsec        = res_s2.start_nsec;
	assign step_ns           = res_s2.step_ns;
	assign watchdog_action   = res_s2.watchdog_action;
	assign watchdog_delay_ns = res_s2.watchdog_delay_ns;

	`WSSW_ASSERT(a_viol_stop, out_valid && violation |-> timer_action == TA_STOP && watchdog_action == WD_NONE, "violation must stop the timer only")
	`WSSW_ASSERT(a_start_arm, out_valid && timer_action == TA_START |-> watchdog_action == WD_ARM && step_ns == '0, "start without watchdog arm")
	`WSSW_ASSERT(a_stall_src, in_stall |-> out_valid && out_stall && valid_s1, "input stalled with free pipeline")
	`WSSW_ASSERT_NR(a_rst_out, !arst_n |=> !out_valid, "result valid after reset")

endmodule

`default_nettype wire

>>> rtl/wssw_cfg.sv
// ----------------------------------------------------------------------------
// wssw_cfg
// APB register file for period and tolerance, plus the derived tolerance in ns.
// ----------------------------------------------------------------------------
`default_nettype none

module wssw_cfg import wssw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic [PERIOD_W-1:0] period_q;
	logic [TOLP_W-1:0]   tolp_q;
	logic [Q100_W-1:0]   q100_q;
	logic [TOL_W-1:0]    tol_q;
	logic                wr;
	logic                idx;
	logic [46:0]         div_prod;

	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[2];
	assign pready = 1'b1;

	// half period / 100, taken from the written value
	assign div_prod = {24'd0, pwdata[PERIOD_W-1:1]} * {23'd0, DIV100_MUL};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			tolp_q   <= TOLP_RST;
			q100_q   <= Q100_RST;
			tol_q    <= TOL_RST;
		end else begin
			if (wr && idx == REG_PERIOD) begin
				period_q <= pwdata[PERIOD_W-1:0];
				q100_q   <= div_prod[DIV100_SHIFT +: Q100_W];
			end
			if (wr && idx == REG_TOL) begin
				tolp_q <= pwdata[TOLP_W-1:0];
			end
			// registered from the stored q100_q and tolp_q, so it trails a write to either register
			tol_q <= {7'd0, q100_q} * {17'd0, tolp_q};
		end
	end

	always_comb begin
		case (idx)
			REG_PERIOD: prdata = {8'd0, period_q};
			REG_TOL:    prdata = {25'd0, tolp_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.half = period_q[PERIOD_W-1:1];
	assign cfg.tol  = tol_q;

endmodule

`default_nettype wire

>>> rtl/wssw_event.sv
// ----------------------------------------------------------------------------
// wssw_event
// Event state (running, level, restarts, last toggle time) and the result of
// one event: start alignment, toggle interval check and watchdog delays.
// ----------------------------------------------------------------------------
`default_nettype none

module wssw_event import wssw_pkg::*; #(
	parameter int SLOT_NS = 10000000,
	parameter int QW      = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire logic [1:0]        func,
	input  wire logic [SEC_W-1:0]  sec,
	input  wire logic [NSEC_W-1:0] nsec,
	input  wire logic [QW-1:0]     slotq,
	input  wire cfg_t              cfg,
	output res_t                   res
);

	localparam int SW    = QW + 1;
	localparam int SLOTS = 1000000000 / SLOT_NS;
	localparam logic [SW-1:0]     SLOTS_C = SW'(SLOTS);
	localparam logic [NSEC_W-1:0] SLOT_C  = NSEC_W'(SLOT_NS);
	localparam logic [31:0]       SLOT3_C = 32'(3 * SLOT_NS);

	logic              running_q;
	logic              level_q;
	logic [31:0]       restart_q;
	logic [SEC_W-1:0]  last_sec_q;
	logic [NSEC_W-1:0] last_nsec_q;
	logic              last_valid_q;

	logic              running_n;
	logic              level_n;
	logic [31:0]       restart_n;
	logic [SEC_W-1:0]  last_sec_n;
	logic [NSEC_W-1:0] last_nsec_n;
	logic              last_valid_n;

	// start alignment
	logic [SW-1:0]      slot_raw;
	logic               slot_wrap;
	logic [SW-1:0]      slot_fin;
	logic [NSEC_W-1:0]  start_ns;
	logic [SEC_W-1:0]   start_s;

	// delays
	logic [24:0]        check;
	logic [31:0]        sdel_sum;
	logic [DELAY_W-1:0] start_delay;
	logic [DELAY_W-1:0] fwd_delay;

	// interval check
	logic [SEC_W-1:0]   ds;
	logic signed [30:0] dn;
	logic signed [32:0] dn_x;
	logic signed [32:0] diff;
	logic               far;
	logic signed [33:0] hd;
	logic [33:0]        dev;
	logic               bad;

	assign slot_raw  = {1'b0, slotq} + SW'(2);
	assign slot_wrap = slot_raw >= SLOTS_C;
	assign slot_fin  = slot_wrap ? slot_raw - SLOTS_C : slot_raw;
	assign start_ns  = {(NSEC_W-SW)'(0), slot_fin} * SLOT_C;
	assign start_s   = sec + {31'd0, slot_wrap};

	assign check       = {2'd0, cfg.half} + {1'b0, cfg.tol};
	assign sdel_sum    = SLOT3_C + {7'd0, check};
	assign start_delay = (sdel_sum > {6'd0, DELAY_MAX}) ? DELAY_MAX : sdel_sum[DELAY_W-1:0];
	assign fwd_delay   = {1'b0, check};

	// only second differences of -1, 0 and +1 can land inside tolerance
	assign ds   = sec - last_sec_q;
	assign dn   = $signed({1'b0, nsec}) - $signed({1'b0, last_nsec_q});
	assign dn_x = {{2{dn[30]}}, dn};

	always_comb begin
		far  = 1'b0;
		diff = dn_x;
		if (ds == '0) begin
			diff = dn_x;
		end else if (ds == 32'd1) begin
			diff = dn_x + 33'sd1000000000;
		end else if (ds == '1) begin
			diff = dn_x - 33'sd1000000000;
		end else begin
			far = 1'b1;
		end
	end

	assign hd  = $signed({11'd0, cfg.half}) - $signed({diff[32], diff});
	assign dev = hd[33] ? 34'(-hd) : 34'(hd);
	assign bad = far || (dev > {10'd0, cfg.tol});

	always_comb begin
		running_n    = running_q;
		level_n      = level_q;
		restart_n    = restart_q;
		last_sec_n   = last_sec_q;
		last_nsec_n  = last_nsec_q;
		last_valid_n = last_valid_q;
		res          = '0;
		case (func)
			FN_ENABLE: begin
				running_n             = 1'b1;
				level_n               = 1'b0;
				last_valid_n          = 1'b0;
				res.timer_action      = TA_START;
				res.start_sec         = start_s;
				res.start_nsec        = start_ns;
				res.watchdog_action   = WD_ARM;
				res.watchdog_delay_ns = start_delay;
			end
			FN_DISABLE: begin
				running_n           = 1'b0;
				level_n             = 1'b0;
				res.timer_action    = TA_STOP;
				res.watchdog_action = WD_CANCEL;
			end
			FN_WATCHDOG: begin
				if (running_q) begin
					level_n               = 1'b0;
					restart_n             = restart_q + 32'd1;
					last_valid_n          = 1'b0;
					res.timer_action      = TA_START;
					res.start_sec         = start_s;
					res.start_nsec        = start_ns;
					res.watchdog_action   = WD_ARM;
					res.watchdog_delay_ns = start_delay;
				end
			end
			FN_TOGGLE: begin
				if (running_q) begin
					// first toggle after a start passes unchecked
					if (!last_valid_q || !bad) begin
						last_sec_n            = sec;
						last_nsec_n           = nsec;
						last_valid_n          = 1'b1;
						level_n               = ~level_q;
						res.timer_action      = TA_FWD;
						res.step_ns           = cfg.half;
						res.watchdog_action   = WD_ARM;
						res.watchdog_delay_ns = fwd_delay;
					end else begin
						res.violation    = 1'b1;
						res.timer_action = TA_STOP;
					end
				end
			end
			default: begin
			end
		endcase
		res.out_level = level_n;
		res.restarts  = restart_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b0;
			level_q      <= 1'b0;
			restart_q    <= '0;
			last_sec_q   <= '0;
			last_nsec_q  <= '0;
			last_valid_q <= 1'b0;
		end else if (go) begin
			running_q    <= running_n;
			level_q      <= level_n;
			restart_q    <= restart_n;
			last_sec_q   <= last_sec_n;
			last_nsec_q  <= last_nsec_n;
			last_valid_q <= last_valid_n;
		end
	end

endmodule

`default_nettype wire

>>> tb/sv/wallclock_synced_square_wave_watchdog_tb.sv
// ----------------------------------------------------------------------------
// wallclock synced square wave watchdog testbench
// Sends time-stamped events (toggle expiry, watchdog expiry, enable, disable)
// through the valid/stall port and checks every result field against a local
// model or a given result. A short list of directed events comes first, then
// random event streams under several register settings and handshake loads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wallclock_synced_square_wave_watchdog_tb;
	import wssw_pkg::*;

	localparam longint SLOT_NS     = 10000000;
	localparam longint NS_SEC      = 1000000000;
	localparam int     QUIET_LIMIT = 3000;
	localparam int     N_PHASES    = 6;

	localparam logic [23:0] PH_PERIOD [N_PHASES] = '{24'd500000, 24'd10000000, 24'hFFFFFF,
		24'd5000000, 24'd2000000, 24'd1000000};
	localparam logic [6:0]  PH_TOLP   [N_PHASES] = '{7'd1, 7'd100, 7'd127, 7'd0, 7'd50, 7'd10};
	localparam int          PH_IDLE   [N_PHASES] = '{0, 68, 0, 14, 0, 14};
	localparam int          PH_STALL  [N_PHASES] = '{0, 0, 68, 14, 0, 14};

	typedef struct {
		logic [1:0]  fn;
		logic [31:0] sec;
		logic [29:0] nsec;
		bit          typed;
		res_t        res;
	} ev_row_t;

	logic clk;
	logic arst_n = 1'b0;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         func = FN_TOGGLE;
	logic [SEC_W-1:0]   now_sec = '0;
	logic [NSEC_W-1:0]  now_nsec = '0;

	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               out_level;
	logic [31:0]        restarts;
	logic               violation;
	logic [1:0]         timer_action;
	logic [SEC_W-1:0]   start_sec;
	logic [NSEC_W-1:0]  start_nsec;
	logic [HALF_W-1:0]  step_ns;
	logic [1:0]         watchdog_action;
	logic [DELAY_W-1:0] watchdog_delay_ns;

	// model copy of registers and state
	logic [23:0] cfg_period = PERIOD_RST;
	logic [6:0]  cfg_tolp = TOLP_RST;
	bit          wv_running = 1'b0;
	bit          wv_level = 1'b0;
	logic [31:0] wv_restarts = '0;
	logic [31:0] wv_last_sec = '0;
	logic [29:0] wv_last_nsec = '0;
	bit          wv_last_ok = 1'b0;

	res_t    pending_actions[$];
	ev_row_t dir_rows[$];
	int unsigned n_fail = 0;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	longint gen_now = 100 * NS_SEC;
	longint gen_start = 0;

	wallclock_synced_square_wave_watchdog #(.SLOT_NS(int'(SLOT_NS))) u_top (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .func, .now_sec, .now_nsec,
		.out_valid, .out_stall, .out_level, .restarts, .violation, .timer_action,
		.start_sec, .start_nsec, .step_ns, .watchdog_action, .watchdog_delay_ns
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic res_t mk_res(logic lvl, logic [31:0] rst, logic viol, logic [1:0] ta,
			logic [31:0] ssec, logic [29:0] snsec, logic [22:0] stp, logic [1:0] wa,
			logic [25:0] dly);
		res_t r;
		r.out_level = lvl;
		r.restarts = rst;
		r.violation = viol;
		r.timer_action = ta;
		r.start_sec = ssec;
		r.start_nsec = snsec;
		r.step_ns = stp;
		r.watchdog_action = wa;
		r.watchdog_delay_ns = dly;
		return r;
	endfunction

	// advances the model by one event and returns the actions it calls for
	function automatic res_t step_wave(logic [1:0] fn, logic [31:0] sec, logic [29:0] nsec);
		res_t        r;
		longint      half, tolv, chk, dly, slot, dsec, diff, dev;
		logic [31:0] ds, ssec;
		bit          rearm;
		r = '0;
		rearm = 1'b0;
		half = longint'(cfg_period) / 2;
		tolv = (half / 100) * longint'(cfg_tolp);
		chk = half + tolv;
		if (fn == FN_ENABLE) begin
			wv_running = 1'b1;
			wv_level = 1'b0;
			rearm = 1'b1;
		end else if (fn == FN_DISABLE) begin
			wv_running = 1'b0;
			wv_level = 1'b0;
			r.timer_action = TA_STOP;
			r.watchdog_action = WD_CANCEL;
		end else if (wv_running && fn == FN_WATCHDOG) begin
			wv_level = 1'b0;
			wv_restarts = wv_restarts + 32'd1;
			rearm = 1'b1;
		end else if (wv_running) begin
			dev = 0;
			if (wv_last_ok) begin
				// seconds difference is signed so a wrap of the seconds counter is harmless
				ds = sec - wv_last_sec;
				dsec = longint'($signed(ds));
				diff = dsec * NS_SEC + (longint'(nsec) - longint'(wv_last_nsec));
				dev = (half > diff) ? half - diff : diff - half;
			end
			if (!wv_last_ok || dev <= tolv) begin
				wv_last_sec = sec;
				wv_last_nsec = nsec;
				wv_last_ok = 1'b1;
				wv_level = !wv_level;
				r.timer_action = TA_FWD;
				r.step_ns = half[22:0];
				r.watchdog_action = WD_ARM;
				dly = (chk > longint'(DELAY_MAX)) ? longint'(DELAY_MAX) : chk;
				r.watchdog_delay_ns = dly[25:0];
			end else begin
				r.violation = 1'b1;
				r.timer_action = TA_STOP;
			end
		end
		if (rearm) begin
			// start two slots ahead, carrying into the next second
			slot = longint'(nsec) / SLOT_NS + 2;
			ssec = sec;
			if (slot >= NS_SEC / SLOT_NS) begin
				ssec = sec + 32'd1;
				slot = slot % (NS_SEC / SLOT_NS);
			end
			r.timer_action = TA_START;
			r.start_sec = ssec;
			r.start_nsec = 30'(slot * SLOT_NS);
			r.watchdog_action = WD_ARM;
			dly = 3 * SLOT_NS + chk;
			if (dly > longint'(DELAY_MAX))
				dly = longint'(DELAY_MAX);
			r.watchdog_delay_ns = dly[25:0];
			wv_last_ok = 1'b0;
		end
		r.out_level = wv_level;
		r.restarts = wv_restarts;
		return r;
	endfunction

	task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic read_reg(input logic rix, input logic [31:0] want);
		logic [31:0] rd;
		apb_xfer(1'b0, {rix, 2'b00}, 32'd0, rd);
		if (rd !== want) begin
			$display("%0t: register %0d expected %0d, got %0d", $time, rix, want, rd);
			n_fail++;
		end
	endtask

	task automatic set_reg(input logic rix, input logic [31:0] val);
		logic [31:0] rd;
		apb_xfer(1'b1, {rix, 2'b00}, val, rd);
		if (rix == REG_PERIOD) begin
			cfg_period = val[23:0];
			read_reg(rix, {8'd0, val[23:0]});
		end else begin
			cfg_tolp = val[6:0];
			read_reg(rix, {25'd0, val[6:0]});
		end
	endtask

	// called and returns at a falling edge
	task automatic send_event(input logic [1:0] fn, input logic [31:0] sec,
			input logic [29:0] nsec, input bit typed, input res_t typed_res, output res_t pred);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		now_sec <= sec;
		now_nsec <= nsec;
		do @(posedge clk); while (in_stall);
		pred = step_wave(fn, sec, nsec);
		pending_actions.push_back(typed ? typed_res : pred);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_actions.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic add_row(input logic [1:0] fn, input logic [31:0] sec, input logic [29:0] nsec,
			input bit typed, input res_t res);
		ev_row_t row;
		row.fn = fn;
		row.sec = sec;
		row.nsec = nsec;
		row.typed = typed;
		row.res = res;
		dir_rows.push_back(row);
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned done, r;
		longint      t, half, tolv, dev;
		logic [1:0]  fn;
		logic [31:0] sec;
		logic [29:0] nsec;
		bit          noise;
		res_t        pred;
		done = 0;
		while (done < count) begin
			r = $urandom_range(0, 99);
			half = longint'(cfg_period) / 2;
			tolv = (half / 100) * longint'(cfg_tolp);
			noise = 1'b0;
			t = gen_now;
			if (r < 4 || (!wv_running && r < 70)) begin
				fn = FN_ENABLE;
				if ($urandom_range(0, 9) == 0)
					t = longint'(32'hFFFFFFFF) * NS_SEC + $urandom_range(900000000, 999999999);
				else
					t = gen_now + $urandom_range(0, 50000000);
			end else if (r < 8) begin
				fn = FN_WATCHDOG;
				t = gen_now + $urandom_range(0, 40000000);
			end else if (r < 10) begin
				fn = FN_DISABLE;
				t = gen_now + $urandom_range(0, 40000000);
			end else if (r < 18) begin
				noise = 1'b1;
				fn = 2'($urandom_range(0, 3));
				sec = $urandom;
				nsec = 30'($urandom);
			end else begin
				fn = FN_TOGGLE;
				if (!wv_last_ok) begin
					t = gen_start + $urandom_range(0, 1000);
				end else begin
					if (r < 75)
						dev = longint'($urandom_range(0, 32'(2 * tolv))) - tolv;
					else if (r < 85)
						dev = ($urandom_range(0, 1) ? tolv : -tolv)
							+ ($urandom_range(0, 1) ? 1 : 0) * ((dev >= 0) ? 1 : 1);
					else
						dev = longint'($urandom_range(0, 32'(3 * tolv + 4))) - (3 * tolv + 4) / 2;
					t = longint'(wv_last_sec) * NS_SEC + longint'(wv_last_nsec) + half + dev;
				end
			end
			if (!noise) begin
				if (t < 0)
					t = 0;
				sec = 32'(t / NS_SEC);
				nsec = 30'(t % NS_SEC);
				gen_now = t;
			end
			if (fn == FN_ENABLE || fn == FN_DISABLE || wv_running)
				done++;
			send_event(fn, sec, nsec, 1'b0, '0, pred);
			if (pred.timer_action == TA_START)
				gen_start = longint'(pred.start_sec) * NS_SEC + longint'(pred.start_nsec);
		end
	endtask

	// receiver side stall
	always @(negedge clk)
		out_stall <= arst_n && ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin
		res_t want, got;
		if (arst_n && out_valid && !out_stall) begin
			got = mk_res(out_level, restarts, violation, timer_action, start_sec, start_nsec,
				step_ns, watchdog_action, watchdog_delay_ns);
			if (pending_actions.size() == 0) begin
				$display("%0t: result transfer with nothing expected, got %h", $time, got);
				n_fail++;
			end else begin
				want = pending_actions.pop_front();
				if (got !== want) begin
					$display("%0t: result mismatch, expected %h, got %h", $time, want, got);
					$display("  level %0d/%0d restarts %0d/%0d violation %0d/%0d",
						want.out_level, got.out_level, want.restarts, got.restarts,
						want.violation, got.violation);
					$display("  timer %0d/%0d start %0d.%0d/%0d.%0d step %0d/%0d",
						want.timer_action, got.timer_action, want.start_sec, want.start_nsec,
						got.start_sec, got.start_nsec, want.step_ns, got.step_ns);
					$display("  watchdog %0d/%0d delay %0d/%0d", want.watchdog_action,
						got.watchdog_action, want.watchdog_delay_ns, got.watchdog_delay_ns);
					n_fail++;
				end
			end
		end
	end

	// ends the run when no transfer happens for too long
	initial begin : hang_guard
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		res_t pred;
		// reset config: half 500000, tolerance 500000, start delay 31 ms
		add_row(FN_TOGGLE, 32'd0, 30'd0, 1'b1, '0);
		add_row(FN_WATCHDOG, 32'hFFFFFFFF, 30'h3FFFFFFF, 1'b1, '0);
		add_row(FN_DISABLE, 32'd0, 30'd0, 1'b1,
			mk_res(1'b0, 32'd0, 1'b0, TA_STOP, 32'd0, 30'd0, 23'd0, WD_CANCEL, 26'd0));
		add_row(FN_ENABLE, 32'd5, 30'd0, 1'b1,
			mk_res(1'b0, 32'd0, 1'b0, TA_START, 32'd5, 30'd20000000, 23'd0, WD_ARM, 26'd31000000));
		// first toggle after a start goes through unchecked
		add_row(FN_TOGGLE, 32'd5, 30'd20000000, 1'b1,
			mk_res(1'b1, 32'd0, 1'b0, TA_FWD, 32'd0, 30'd0, 23'd500000, WD_ARM, 26'd1000000));
		add_row(FN_TOGGLE, 32'd5, 30'd20500000, 1'b0, '0);
		add_row(FN_TOGGLE, 32'd5, 30'd21500000, 1'b0, '0);
		add_row(FN_TOGGLE, 32'd5, 30'd22500001, 1'b0, '0);
		// checked again after a violation
		add_row(FN_TOGGLE, 32'd5, 30'd22000000, 1'b0, '0);
		add_row(FN_TOGGLE, 32'd5, 30'd22000000, 1'b0, '0);
		add_row(FN_WATCHDOG, 32'd5, 30'd985000000, 1'b1,
			mk_res(1'b0, 32'd1, 1'b0, TA_START, 32'd6, 30'd0, 23'd0, WD_ARM, 26'd31000000));
		// enable while running, start carries past the seconds wrap
		add_row(FN_ENABLE, 32'hFFFFFFFF, 30'd999999999, 1'b1,
			mk_res(1'b0, 32'd1, 1'b0, TA_START, 32'd0, 30'd10000000, 23'd0, WD_ARM, 26'd31000000));
		add_row(FN_ENABLE, 32'hFFFFFFFF, 30'd970000000, 1'b1,
			mk_res(1'b0, 32'd1, 1'b0, TA_START, 32'hFFFFFFFF, 30'd990000000, 23'd0, WD_ARM,
				26'd31000000));
		add_row(FN_TOGGLE, 32'hFFFFFFFF, 30'd999800000, 1'b1,
			mk_res(1'b1, 32'd1, 1'b0, TA_FWD, 32'd0, 30'd0, 23'd500000, WD_ARM, 26'd1000000));
		// interval across the seconds wrap, then a negative interval
		add_row(FN_TOGGLE, 32'd0, 30'd300000, 1'b0, '0);
		add_row(FN_TOGGLE, 32'd0, 30'd0, 1'b0, '0);
		// nanoseconds beyond one second
		add_row(FN_ENABLE, 32'd7, 30'h3FFFFFFF, 1'b1,
			mk_res(1'b0, 32'd1, 1'b0, TA_START, 32'd8, 30'd90000000, 23'd0, WD_ARM, 26'd31000000));
		add_row(FN_TOGGLE, 32'd8, 30'h3FFFFFFF, 1'b0, '0);
		add_row(FN_WATCHDOG, 32'd8, 30'h3FFFFFFF, 1'b0, '0);
		add_row(FN_DISABLE, 32'd9, 30'd0, 1'b1,
			mk_res(1'b0, 32'd2, 1'b0, TA_STOP, 32'd0, 30'd0, 23'd0, WD_CANCEL, 26'd0));
		add_row(FN_TOGGLE, 32'd9, 30'd0, 1'b1,
			mk_res(1'b0, 32'd2, 1'b0, TA_NONE, 32'd0, 30'd0, 23'd0, WD_NONE, 26'd0));
		add_row(FN_WATCHDOG, 32'd9, 30'd5, 1'b1,
			mk_res(1'b0, 32'd2, 1'b0, TA_NONE, 32'd0, 30'd0, 23'd0, WD_NONE, 26'd0));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		read_reg(REG_PERIOD, {8'd0, PERIOD_RST});
		read_reg(REG_TOL, {25'd0, TOLP_RST});

		foreach (dir_rows[i])
			send_event(dir_rows[i].fn, dir_rows[i].sec, dir_rows[i].nsec, dir_rows[i].typed,
				dir_rows[i].res, pred);

		for (int p = 0; p < N_PHASES; p++) begin
			wait_idle();
			set_reg(REG_PERIOD, {8'd0, PH_PERIOD[p]});
			set_reg(REG_TOL, {25'd0, PH_TOLP[p]});
			repeat (2) @(negedge clk);
			idle_pct = PH_IDLE[p];
			stall_pct = PH_STALL[p];
			run_random(85);
		end

		wait_idle();
		if (n_fail == 0 && pending_actions.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/wssw_pkg.sv
rtl/wssw_cfg.sv
rtl/wssw_event.sv
rtl/wallclock_synced_square_wave_watchdog.sv
tb/sv/wallclock_synced_square_wave_watchdog_tb.sv
